// ----- rtl/core/aiff_pkg.sv -----
// shared types and constants for the aiff header parser
`default_nettype none
package aiff_pkg;
    typedef enum logic [3:0] {
        PH_FORM_ID, PH_FORM_SIZE, PH_FORM_TYPE, PH_CHUNK_ID, PH_CHUNK_SZ,
        PH_COMM, PH_NAME, PH_SSND, PH_SKIP, PH_DEAD
    } phase_t;

    typedef enum logic [2:0] {
        SQ_PARSE, SQ_RATE, SQ_MUL, SQ_DIV, SQ_OUT
    } seq_t;

    localparam logic [31:0] TAG_FORM = 32'h464F524D;
    localparam logic [31:0] TAG_AIFF = 32'h41494646;
    localparam logic [31:0] TAG_AIFC = 32'h41494643;
    localparam logic [31:0] TAG_COMM = 32'h434F4D4D;
    localparam logic [31:0] TAG_SSND = 32'h53534E44;
    localparam logic [31:0] TAG_NONE = 32'h4E4F4E45;
    localparam logic [31:0] TAG_FL32 = 32'h666C3332;
    localparam logic [31:0] TAG_FL64 = 32'h666C3634;
    localparam logic [31:0] TAG_ALAW = 32'h414C4157;
    localparam logic [15:0] EXP_BIAS = 16'd16383;
    localparam logic [31:0] SIZE_SIGN = 32'h80000000;
    localparam logic [9:0] MS_SCALE = 10'd1000;

    localparam logic [1:0] FMT_UNKNOWN = 2'd0;
    localparam logic [1:0] FMT_PCM = 2'd1;
    localparam logic [1:0] FMT_FLOAT = 2'd2;
    localparam logic [1:0] FMT_ALAW = 2'd3;

    typedef struct packed {
        logic        form_valid;
        logic        sound_seen;
        logic        compressed;
        logic [1:0]  format;
        logic [15:0] channels;
        logic [15:0] bits;
        logic [15:0] rate_exp;
        logic [31:0] rate_mant;
        logic [31:0] frames;
        logic [31:0] sound_start;
        logic [31:0] sound_length;
    } hdr_t;

    function automatic logic [1:0] map_compression(input logic [31:0] t);
        logic [1:0] r;
        begin
            r = FMT_UNKNOWN;
            if (t == TAG_NONE) r = FMT_PCM;
            else if (t == TAG_FL32 || t == TAG_FL64) r = FMT_FLOAT;
            else if (t == TAG_ALAW) r = FMT_ALAW;
            return r;
        end
    endfunction
endpackage
`default_nettype wire

// ----- rtl/core/aiff_parse.sv -----
// byte-level chunk walker that collects header fields
`default_nettype none
module aiff_parse #(
    parameter int POSITION_BITS = 32
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                step,
    input  wire logic                clear,
    input  wire logic [7:0]          data_byte,
    output aiff_pkg::hdr_t           hdr
);
    localparam int PW = POSITION_BITS;

    aiff_pkg::phase_t phase_reg, phase_next;
    logic [PW-1:0] pos_reg, pos_next, end_reg, end_next, start_reg, start_next;
    logic [31:0] acc_reg, tag_reg, tag_next, size_reg, size_next;
    logic [4:0] idx_reg, idx_next;
    logic [7:0] name_reg, name_next;
    aiff_pkg::hdr_t h_reg, h_next;
    logic [31:0] acc_new;
    logic [PW-1:0] pos_after, size_ext;

    assign hdr = '{form_valid: h_reg.form_valid, sound_seen: h_reg.sound_seen,
        compressed: h_reg.compressed, format: h_reg.format, channels: h_reg.channels,
        bits: h_reg.bits, rate_exp: h_reg.rate_exp, rate_mant: h_reg.rate_mant,
        frames: h_reg.frames, sound_start: 32'(start_reg),
        sound_length: h_reg.sound_length};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= aiff_pkg::PH_FORM_ID;
            pos_reg <= '0; end_reg <= '0; start_reg <= '0;
            acc_reg <= '0; tag_reg <= '0; size_reg <= '0;
            idx_reg <= '0; name_reg <= '0; h_reg <= '0;
        end
        else if (clear)
        begin
            phase_reg <= aiff_pkg::PH_FORM_ID;
            pos_reg <= '0; end_reg <= '0; start_reg <= '0;
            acc_reg <= '0; tag_reg <= '0; size_reg <= '0;
            idx_reg <= '0; name_reg <= '0; h_reg <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            pos_reg <= pos_next; end_reg <= end_next; start_reg <= start_next;
            acc_reg <= acc_new; tag_reg <= tag_next; size_reg <= size_next;
            idx_reg <= idx_next; name_reg <= name_next; h_reg <= h_next;
        end
    end

    always_comb
    begin
        acc_new = {acc_reg[23:0], data_byte};
        pos_after = pos_reg + PW'(1);
        pos_next = pos_after;
        size_ext = PW'(signed'(acc_new));
        phase_next = phase_reg;
        end_next = end_reg;
        start_next = start_reg;
        tag_next = tag_reg;
        size_next = size_reg;
        idx_next = idx_reg;
        name_next = name_reg;
        h_next = h_reg;
        case (phase_reg)
            aiff_pkg::PH_FORM_ID:
            begin
                if (idx_reg == 5'd3)
                begin
                    idx_next = '0;
                    phase_next = (acc_new == aiff_pkg::TAG_FORM) ? aiff_pkg::PH_FORM_SIZE
                                                                  : aiff_pkg::PH_DEAD;
                end
                else idx_next = idx_reg + 5'd1;
            end
            aiff_pkg::PH_FORM_SIZE:
            begin
                if (idx_reg == 5'd3)
                begin
                    idx_next = '0;
                    phase_next = aiff_pkg::PH_FORM_TYPE;
                end
                else idx_next = idx_reg + 5'd1;
            end
            aiff_pkg::PH_FORM_TYPE:
            begin
                if (idx_reg == 5'd3)
                begin
                    idx_next = '0;
                    if (acc_new == aiff_pkg::TAG_AIFF || acc_new == aiff_pkg::TAG_AIFC)
                    begin
                        h_next.compressed = (acc_new == aiff_pkg::TAG_AIFC);
                        h_next.form_valid = 1'b1;
                        phase_next = aiff_pkg::PH_CHUNK_ID;
                        tag_next = '0;
                    end
                    else phase_next = aiff_pkg::PH_DEAD;
                end
                else idx_next = idx_reg + 5'd1;
            end
            aiff_pkg::PH_CHUNK_ID:
            begin
                tag_next = {tag_reg[23:0], data_byte};
                if (idx_reg < 5'd4) idx_next = idx_reg + 5'd1;
                if (idx_next >= 5'd4 && tag_next[31:24] != 8'd0)
                begin
                    phase_next = aiff_pkg::PH_CHUNK_SZ;
                    idx_next = '0;
                end
            end
            aiff_pkg::PH_CHUNK_SZ:
            begin
                if (idx_reg == 5'd3)
                begin
                    size_next = acc_new;
                    end_next = pos_after + size_ext;
                    idx_next = '0;
                    if (tag_reg == aiff_pkg::TAG_COMM) phase_next = aiff_pkg::PH_COMM;
                    else if (tag_reg == aiff_pkg::TAG_SSND) phase_next = aiff_pkg::PH_SSND;
                    else
                    begin
                        phase_next = (end_next > pos_after) ? aiff_pkg::PH_SKIP
                                                             : aiff_pkg::PH_CHUNK_ID;
                        tag_next = '0;
                    end
                end
                else idx_next = idx_reg + 5'd1;
            end
            aiff_pkg::PH_COMM:
            begin
                idx_next = idx_reg + 5'd1;
                case (idx_reg)
                    5'd1: h_next.channels = acc_new[15:0];
                    5'd5: h_next.frames = acc_new;
                    5'd7: h_next.bits = acc_new[15:0];
                    5'd9: h_next.rate_exp = acc_new[15:0];
                    5'd13: h_next.rate_mant = acc_new;
                    5'd17:
                    begin
                        if (!h_reg.compressed)
                        begin
                            h_next.format = aiff_pkg::FMT_PCM;
                            phase_next = (end_reg > pos_after) ? aiff_pkg::PH_SKIP
                                                                : aiff_pkg::PH_CHUNK_ID;
                            idx_next = '0;
                            tag_next = '0;
                        end
                    end
                    5'd21: h_next.format = aiff_pkg::map_compression(acc_new);
                    5'd22:
                    begin
                        if (data_byte != 8'd0)
                        begin
                            name_next = data_byte;
                            phase_next = aiff_pkg::PH_NAME;
                        end
                        else
                        begin
                            phase_next = (end_reg > pos_after) ? aiff_pkg::PH_SKIP
                                                                : aiff_pkg::PH_CHUNK_ID;
                            idx_next = '0;
                            tag_next = '0;
                        end
                    end
                    default: ;
                endcase
            end
            aiff_pkg::PH_NAME:
            begin
                name_next = name_reg - 8'd1;
                if (name_next == 8'd0)
                begin
                    phase_next = (end_reg > pos_after) ? aiff_pkg::PH_SKIP
                                                        : aiff_pkg::PH_CHUNK_ID;
                    idx_next = '0;
                    tag_next = '0;
                end
            end
            aiff_pkg::PH_SSND:
            begin
                if (idx_reg == 5'd3)
                begin
                    start_next = PW'(acc_new) + PW'(4) + pos_after;
                    h_next.sound_length = size_reg - 32'd8;
                    h_next.sound_seen = 1'b1;
                    phase_next = (end_reg > pos_after) ? aiff_pkg::PH_SKIP
                                                        : aiff_pkg::PH_CHUNK_ID;
                    idx_next = '0;
                    tag_next = '0;
                end
                else idx_next = idx_reg + 5'd1;
            end
            aiff_pkg::PH_SKIP:
            begin
                if (pos_after >= end_reg)
                begin
                    phase_next = aiff_pkg::PH_CHUNK_ID;
                    idx_next = '0;
                    tag_next = '0;
                end
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

// ----- rtl/core/aiff_arith.sv -----
// shared shift-and-round, multiply and restoring divide unit for rate and duration
`default_nettype none
module aiff_arith (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [15:0] rate_exp,
    input  wire logic [31:0] rate_mant,
    input  wire logic [31:0] frames,
    output logic             done,
    output logic [31:0]      rate,
    output logic [31:0]      duration,
    output logic             error
);
    aiff_pkg::seq_t st_reg, st_next;
    logic [63:0] work_reg, work_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] rate_reg, rate_next;
    logic [5:0] cnt_reg, cnt_next;
    logic err_reg, err_next, done_reg, done_next;
    logic [16:0] e;
    logic [4:0] sh;
    logic [32:0] rsum, tmp;
    logic [32:0] rdiff;

    assign done = done_reg;
    assign rate = rate_reg;
    assign duration = work_reg[63:32] != 32'd0 ? 32'hFFFFFFFF : work_reg[31:0];
    assign error = err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= aiff_pkg::SQ_PARSE;
            done_reg <= 1'b0;
            err_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
            done_reg <= done_next;
            err_reg <= err_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg <= rem_next;
        rate_reg <= rate_next;
    end

    always_comb
    begin
        st_next = st_reg;
        work_next = work_reg;
        rem_next = rem_reg;
        rate_next = rate_reg;
        cnt_next = cnt_reg;
        err_next = err_reg;
        done_next = 1'b0;
        e = {1'b0, rate_exp} - {1'b0, aiff_pkg::EXP_BIAS};
        sh = 5'd31 - e[4:0];
        tmp = {1'b0, rate_mant} >> sh;
        rsum = (sh == 5'd0) ? {1'b0, rate_mant}
                            : tmp + 33'(sh == 5'd0 ? 1'b0 : rate_mant[sh - 5'd1]);
        tmp = {rem_reg[31:0], work_reg[63]};
        rdiff = tmp - {1'b0, rate_reg};
        case (st_reg)
            aiff_pkg::SQ_PARSE:
            begin
                if (start) st_next = aiff_pkg::SQ_RATE;
            end
            aiff_pkg::SQ_RATE:
            begin
                work_next = '0;
                if (e[16])
                begin
                    err_next = 1'b1;
                    rate_next = '0;
                    st_next = aiff_pkg::SQ_OUT;
                end
                else if (e[15:0] > 16'd31)
                begin
                    err_next = 1'b1;
                    rate_next = (rate_mant != 32'd0) ? 32'hFFFFFFFF : 32'd0;
                    st_next = aiff_pkg::SQ_OUT;
                end
                else
                begin
                    rate_next = rsum[32] ? 32'hFFFFFFFF : rsum[31:0];
                    err_next = (rsum == 33'd0);
                    st_next = (rsum == 33'd0) ? aiff_pkg::SQ_OUT : aiff_pkg::SQ_MUL;
                end
            end
            aiff_pkg::SQ_MUL:
            begin
                work_next = 64'(frames) * 64'(aiff_pkg::MS_SCALE);
                rem_next = '0;
                cnt_next = '0;
                st_next = aiff_pkg::SQ_DIV;
            end
            aiff_pkg::SQ_DIV:
            begin
                if (!rdiff[32])
                begin
                    rem_next = rdiff;
                    work_next = {work_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_next = tmp;
                    work_next = {work_reg[62:0], 1'b0};
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63) st_next = aiff_pkg::SQ_OUT;
            end
            aiff_pkg::SQ_OUT:
            begin
                done_next = 1'b1;
                st_next = aiff_pkg::SQ_PARSE;
            end
            default: st_next = aiff_pkg::SQ_PARSE;
        endcase
    end
endmodule
`default_nettype wire

// ----- rtl/core/aiff_header_parser.sv -----
// top level of the aiff and aifc header parser
//   channel  signals                               dir
//   in       in_valid in_ready data_byte end_of_file  in
//   out      out_valid out_ready + summary fields     out
// one byte per cycle while parsing; the end-of-file byte starts the summary,
// which is offered after the rate round, the multiply and the 64-step divide,
// or right after the rate round when the rate is in error
// in_ready is low from the end-of-file byte until the summary is taken
// reset clears all parse state; the block clears itself after each summary
`default_nettype none
module aiff_header_parser #(
    parameter int POSITION_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        end_of_file,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             header_ok,
    output logic             audio_found,
    output logic             is_compressed,
    output logic [1:0]       format_code,
    output logic [15:0]      channel_count,
    output logic [15:0]      sample_bits,
    output logic [13:0]      sample_bytes,
    output logic [31:0]      sample_rate,
    output logic [31:0]      duration_ms,
    output logic [31:0]      data_start,
    output logic [31:0]      data_length,
    output logic             rate_error
);
    logic busy_reg, busy_next, ovalid_reg, ovalid_next;
    logic acc, fin, done, err;
    logic [31:0] rate, dur;
    aiff_pkg::hdr_t hdr;
    logic [16:0] bsum;

    assign in_ready = !busy_reg;
    assign acc = in_valid && in_ready;
    assign fin = out_valid && out_ready;
    assign out_valid = ovalid_reg;

    aiff_parse #(.POSITION_BITS(POSITION_BITS)) u_parse (
        .clk(clk), .rst_n(rst_n), .step(acc), .clear(fin),
        .data_byte(data_byte), .hdr(hdr)
    );

    aiff_arith u_arith (
        .clk(clk), .rst_n(rst_n), .start(acc && end_of_file),
        .rate_exp(hdr.rate_exp), .rate_mant(hdr.rate_mant), .frames(hdr.frames),
        .done(done), .rate(rate), .duration(dur), .error(err)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        ovalid_next = ovalid_reg;
        if (acc && end_of_file) busy_next = 1'b1;
        if (done) ovalid_next = 1'b1;
        if (fin)
        begin
            ovalid_next = 1'b0;
            busy_next = 1'b0;
        end
    end

    assign bsum = {1'b0, hdr.bits} + 17'd7;
    assign header_ok = hdr.form_valid;
    assign audio_found = hdr.sound_seen;
    assign is_compressed = hdr.compressed;
    assign format_code = hdr.format;
    assign channel_count = hdr.channels;
    assign sample_bits = hdr.bits;
    assign sample_bytes = bsum[16:3];
    assign sample_rate = rate;
    assign duration_ms = err ? 32'd0 : dur;
    assign data_start = hdr.sound_start;
    assign data_length = hdr.sound_length;
    assign rate_error = err;
endmodule
`default_nettype wire
